// ===== src/igs_pkg.sv =====
// ----------------------------------------------------------------------------
// igs_pkg
// Widths, register indexes and reset values shared by the sampler and its
// checker.
// ----------------------------------------------------------------------------
package igs_pkg;

    // Field and register widths
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_LAMBDA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_MU      = 1'd1;

    // Reset value of both registers: 1.0 in Q16.16
    localparam logic [DATA_W-1:0] CFG_RESET = 32'h0001_0000;

    // Internal widths
    localparam int Y_W   = 63;   // nu^2, Q.56, at most 2^62
    localparam int P_W   = 94;   // mu*y, Q.72
    localparam int A_W   = 54;   // a, Q.32
    localparam int AH_W  = A_W - DATA_W;
    localparam int LA_W  = 86;   // lambda*a
    localparam int R_W   = 109;  // radicand, Q.64
    localparam int S_W   = 55;   // root, Q.32
    localparam int DEN_W = 56;   // s + a
    localparam int NUM_W = 87;   // mu*(s - a)

endpackage

// ===== src/inverse_gaussian_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// inverse_gaussian_sampler_unit
// Inverse Gaussian variate from one normal and one uniform draw, fixed point.
// ----------------------------------------------------------------------------
// Pipeline: front stages, the 55-stage square root and the two 32-stage
//   restoring dividers.
// Throughput: one word per cycle; a one-word skid after the output register
//   lets input flow on while a result waits, o_stall rises only when it fills.
// Reset: synchronous, active low; clears valid bits and skid, sets lambda and
//   mu to 1.0. No clearing pass.
module inverse_gaussian_sampler_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [igs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [igs_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [igs_pkg::DATA_W-1:0]   i_normal_sample,
    input  logic [igs_pkg::DATA_W-1:0]          i_uniform_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [igs_pkg::DATA_W-1:0]          o_variate,
    output logic                                o_took_reciprocal,
    output logic                                o_saturated
);

    localparam int DW    = igs_pkg::DATA_W;
    localparam int VW    = (VALUE_WIDTH > DW) ? DW : VALUE_WIDTH;
    localparam logic [DW-1:0] VMAX = {DW{1'b1}} >> (DW - VW);
    localparam int SQ_N  = igs_pkg::S_W;
    localparam int DV_N  = DW;
    localparam int RC_N  = DW;
    localparam int NSTG  = 7 + SQ_N + 3 + DV_N + 2 + RC_N + 1;
    localparam int TW    = igs_pkg::R_W + 1;

    // Configuration registers
    logic [DW-1:0] r_lam, r_mu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam <= igs_pkg::CFG_RESET;
            r_mu  <= igs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                igs_pkg::REG_SHAPE_LAMBDA: r_lam <= i_cfg_data;
                igs_pkg::REG_MEAN_MU:      r_mu  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: stops only while the skid holds a word
    logic en;
    logic r_sv;
    assign en      = !r_sv;
    assign o_stall = r_sv;

    // Valid bits travel alongside the data
    logic [NSTG-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Front stages: y = nu^2, a = mu*y, radicand
    logic [DW-1:0]                 raw_n, mag;
    logic [DW-1:0]                 r1_mag, r1_z, r2_z, r3_z, r4_z, r5_z, r6_z, r7_z;
    logic [igs_pkg::Y_W-1:0]       r2_y;
    logic [63:0]                   r3_pp_lo;
    logic [62:0]                   r3_pp_hi;
    logic [igs_pkg::P_W-1:0]       p_sum;
    logic [igs_pkg::A_W-1:0]       r4_a, r5_a, r6_a, r7_a;
    logic [63:0]                   r5_m_ll, r5_l_l;
    logic [DW+igs_pkg::AH_W-1:0]   r5_m_lh, r5_l_h;
    logic [2*igs_pkg::AH_W-1:0]    r5_m_hh;
    logic [igs_pkg::R_W-1:0]       r6_sq, r7_rad;
    logic [igs_pkg::LA_W-1:0]      r6_la;

    assign raw_n = DW'(i_normal_sample);
    assign mag   = raw_n[DW-1] ? (DW'(0) - raw_n) : raw_n;
    assign p_sum = (igs_pkg::P_W'(r3_pp_hi) << DW) + igs_pkg::P_W'(r3_pp_lo);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mag   <= mag;
            r1_z     <= i_uniform_sample;
            r2_y     <= igs_pkg::Y_W'(r1_mag * r1_mag);
            r2_z     <= r1_z;
            r3_pp_lo <= r_mu * r2_y[DW-1:0];
            r3_pp_hi <= r_mu * r2_y[igs_pkg::Y_W-1:DW];
            r3_z     <= r2_z;
            r4_a     <= p_sum[igs_pkg::P_W-1:40];
            r4_z     <= r3_z;
            r5_m_ll  <= r4_a[DW-1:0] * r4_a[DW-1:0];
            r5_m_lh  <= r4_a[DW-1:0] * r4_a[igs_pkg::A_W-1:DW];
            r5_m_hh  <= r4_a[igs_pkg::A_W-1:DW] * r4_a[igs_pkg::A_W-1:DW];
            r5_l_l   <= r_lam * r4_a[DW-1:0];
            r5_l_h   <= r_lam * r4_a[igs_pkg::A_W-1:DW];
            r5_a     <= r4_a;
            r5_z     <= r4_z;
            r6_sq    <= (igs_pkg::R_W'(r5_m_hh) << 64) + (igs_pkg::R_W'(r5_m_lh) << 33)
                        + igs_pkg::R_W'(r5_m_ll);
            r6_la    <= (igs_pkg::LA_W'(r5_l_h) << DW) + igs_pkg::LA_W'(r5_l_l);
            r6_a     <= r5_a;
            r6_z     <= r5_z;
            r7_rad   <= r6_sq + (igs_pkg::R_W'(r6_la) << 18);
            r7_a     <= r6_a;
            r7_z     <= r6_z;
        end
    end

    // Square root, one result bit per stage
    logic [igs_pkg::R_W-1:0] r_sq_rem  [SQ_N];
    logic [igs_pkg::S_W-1:0] r_sq_root [SQ_N];
    logic [igs_pkg::A_W-1:0] r_sq_a    [SQ_N];
    logic [DW-1:0]           r_sq_z    [SQ_N];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam int B = SQ_N - 1 - k;
        logic [igs_pkg::R_W-1:0] rem_in;
        logic [igs_pkg::S_W-1:0] root_in;
        logic [igs_pkg::A_W-1:0] a_in;
        logic [DW-1:0]           z_in;
        logic [TW-1:0]           trial;
        if (k == 0) begin : g_first
            assign rem_in  = r7_rad;
            assign root_in = '0;
            assign a_in    = r7_a;
            assign z_in    = r7_z;
        end else begin : g_next
            assign rem_in  = r_sq_rem[k-1];
            assign root_in = r_sq_root[k-1];
            assign a_in    = r_sq_a[k-1];
            assign z_in    = r_sq_z[k-1];
        end
        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (en) begin
                if ({1'b0, rem_in} >= trial) begin
                    r_sq_rem[k]  <= rem_in - trial[igs_pkg::R_W-1:0];
                    r_sq_root[k] <= root_in | (igs_pkg::S_W'(1) << B);
                end else begin
                    r_sq_rem[k]  <= rem_in;
                    r_sq_root[k] <= root_in;
                end
                r_sq_a[k] <= a_in;
                r_sq_z[k] <= z_in;
            end
        end
    end

    // Numerator mu*(s - a) and denominator s + a
    logic [igs_pkg::S_W-1:0]     r8_dif;
    logic [igs_pkg::DEN_W-1:0]   r8_den, r9_den, r10_den;
    logic                        r8_az, r9_az, r10_az;
    logic [DW-1:0]               r8_z, r9_z, r10_z;
    logic [63:0]                 r9_pm_l;
    logic [DW+igs_pkg::S_W-DW-1:0] r9_pm_h;
    logic [igs_pkg::NUM_W-1:0]   r10_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_dif  <= r_sq_root[SQ_N-1] - igs_pkg::S_W'(r_sq_a[SQ_N-1]);
            r8_den  <= igs_pkg::DEN_W'(r_sq_root[SQ_N-1]) + igs_pkg::DEN_W'(r_sq_a[SQ_N-1]);
            r8_az   <= (r_sq_a[SQ_N-1] == '0);
            r8_z    <= r_sq_z[SQ_N-1];
            r9_pm_l <= r_mu * r8_dif[DW-1:0];
            r9_pm_h <= r_mu * r8_dif[igs_pkg::S_W-1:DW];
            r9_den  <= r8_den;
            r9_az   <= r8_az;
            r9_z    <= r8_z;
            r10_num <= (igs_pkg::NUM_W'(r9_pm_h) << DW) + igs_pkg::NUM_W'(r9_pm_l);
            r10_den <= r9_den;
            r10_az  <= r9_az;
            r10_z   <= r9_z;
        end
    end

    // Candidate x1: restoring divider, one quotient bit per stage
    logic [igs_pkg::DEN_W-1:0] r_dv_rem [DV_N];
    logic [DW-1:0]             r_dv_lo  [DV_N];
    logic [DW-1:0]             r_dv_q   [DV_N];
    logic [igs_pkg::DEN_W-1:0] r_dv_den [DV_N];
    logic                      r_dv_az  [DV_N];
    logic [DW-1:0]             r_dv_z   [DV_N];

    for (genvar k = 0; k < DV_N; k++) begin : g_div
        localparam int B = DV_N - 1 - k;
        logic [igs_pkg::DEN_W-1:0] rem_in, den_in;
        logic [DW-1:0]             lo_in, q_in, z_in;
        logic                      az_in;
        logic [igs_pkg::DEN_W:0]   rem2;
        if (k == 0) begin : g_first
            assign rem_in = igs_pkg::DEN_W'(r10_num[igs_pkg::NUM_W-1:DW]);
            assign lo_in  = r10_num[DW-1:0];
            assign q_in   = '0;
            assign den_in = r10_den;
            assign az_in  = r10_az;
            assign z_in   = r10_z;
        end else begin : g_next
            assign rem_in = r_dv_rem[k-1];
            assign lo_in  = r_dv_lo[k-1];
            assign q_in   = r_dv_q[k-1];
            assign den_in = r_dv_den[k-1];
            assign az_in  = r_dv_az[k-1];
            assign z_in   = r_dv_z[k-1];
        end
        assign rem2 = {rem_in, lo_in[B]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem2 >= {1'b0, den_in}) begin
                    r_dv_rem[k] <= igs_pkg::DEN_W'(rem2 - {1'b0, den_in});
                    r_dv_q[k]   <= q_in | (DW'(1) << B);
                end else begin
                    r_dv_rem[k] <= rem2[igs_pkg::DEN_W-1:0];
                    r_dv_q[k]   <= q_in;
                end
                r_dv_lo[k]  <= lo_in;
                r_dv_den[k] <= den_in;
                r_dv_az[k]  <= az_in;
                r_dv_z[k]   <= z_in;
            end
        end
    end

    // Acceptance test z*(mu + x1) <= mu, and mu^2 for the reciprocal
    logic [DW-1:0] x1;
    logic [DW:0]   mu_x1;
    logic [DW-1:0] r11_x1, r12_x1;
    logic [DW:0]   r11_dummy_free;
    logic [DW*2:0] r11_prod;
    logic [63:0]   r11_musq, r12_musq;
    logic          r12_acc, r12_ovf, r12_x1z;

    assign x1    = r_dv_az[DV_N-1] ? r_mu : r_dv_q[DV_N-1];
    assign mu_x1 = {1'b0, r_mu} + {1'b0, x1};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_x1         <= x1;
            r11_dummy_free <= mu_x1;
            r11_prod       <= r_dv_z[DV_N-1] * mu_x1;
            r11_musq       <= r_mu * r_mu;
            r12_x1         <= r11_x1;
            r12_musq       <= r11_musq;
            r12_acc        <= (r11_prod <= {1'b0, r_mu, DW'(0)});
            r12_ovf        <= (r11_musq[63:DW] >= r11_x1) && (r11_dummy_free != '0);
            r12_x1z        <= (r11_x1 == '0);
        end
    end

    // Reciprocal mu^2/x1: restoring divider, 32 quotient bits
    logic [DW-1:0] r_rc_rem [RC_N];
    logic [DW-1:0] r_rc_lo  [RC_N];
    logic [DW-1:0] r_rc_q   [RC_N];
    logic [DW-1:0] r_rc_x1  [RC_N];
    logic          r_rc_acc [RC_N];
    logic          r_rc_ovf [RC_N];
    logic          r_rc_x1z [RC_N];

    for (genvar k = 0; k < RC_N; k++) begin : g_rcp
        localparam int B = RC_N - 1 - k;
        logic [DW-1:0] rem_in, lo_in, q_in, x1_in;
        logic          acc_in, ovf_in, x1z_in;
        logic [DW:0]   rem2;
        if (k == 0) begin : g_first
            assign rem_in = r12_musq[63:DW];
            assign lo_in  = r12_musq[DW-1:0];
            assign q_in   = '0;
            assign x1_in  = r12_x1;
            assign acc_in = r12_acc;
            assign ovf_in = r12_ovf;
            assign x1z_in = r12_x1z;
        end else begin : g_next
            assign rem_in = r_rc_rem[k-1];
            assign lo_in  = r_rc_lo[k-1];
            assign q_in   = r_rc_q[k-1];
            assign x1_in  = r_rc_x1[k-1];
            assign acc_in = r_rc_acc[k-1];
            assign ovf_in = r_rc_ovf[k-1];
            assign x1z_in = r_rc_x1z[k-1];
        end
        assign rem2 = {rem_in, lo_in[B]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem2 >= {1'b0, x1_in}) begin
                    r_rc_rem[k] <= DW'(rem2 - {1'b0, x1_in});
                    r_rc_q[k]   <= q_in | (DW'(1) << B);
                end else begin
                    r_rc_rem[k] <= rem2[DW-1:0];
                    r_rc_q[k]   <= q_in;
                end
                r_rc_lo[k]  <= lo_in;
                r_rc_x1[k]  <= x1_in;
                r_rc_acc[k] <= acc_in;
                r_rc_ovf[k] <= ovf_in;
                r_rc_x1z[k] <= x1z_in;
            end
        end
    end

    // Result select and saturation
    logic [DW-1:0] sel_res;
    logic          sel_took, sel_sat;
    logic [DW-1:0] r13_res;
    logic          r13_took, r13_sat;

    always_comb begin
        sel_took = 1'b0;
        sel_sat  = 1'b0;
        if (r_rc_acc[RC_N-1]) begin
            sel_res = r_rc_x1[RC_N-1];
        end else begin
            sel_took = 1'b1;
            if (r_rc_x1z[RC_N-1] || r_rc_ovf[RC_N-1]) begin
                sel_res = VMAX;
                sel_sat = 1'b1;
            end else begin
                sel_res = r_rc_q[RC_N-1];
            end
        end
        if (sel_res > VMAX) begin
            sel_res = VMAX;
            sel_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_res  <= sel_res;
            r13_took <= sel_took;
            r13_sat  <= sel_sat;
        end
    end

    // Output register with one-word skid
    logic          leave, out_take;
    logic          r_ov;
    logic [DW-1:0] r_od_res, r_sd_res;
    logic          r_od_took, r_od_sat, r_sd_took, r_sd_sat;

    assign leave    = en && r_vld[NSTG-1];
    assign out_take = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (out_take) begin
                r_sv <= 1'b0;
            end
        end else if (leave) begin
            if (r_ov && !out_take) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_take) begin
                r_od_res  <= r_sd_res;
                r_od_took <= r_sd_took;
                r_od_sat  <= r_sd_sat;
            end
        end else if (leave) begin
            if (r_ov && !out_take) begin
                r_sd_res  <= r13_res;
                r_sd_took <= r13_took;
                r_sd_sat  <= r13_sat;
            end else begin
                r_od_res  <= r13_res;
                r_od_took <= r13_took;
                r_od_sat  <= r13_sat;
            end
        end
    end

    assign o_valid           = r_ov;
    assign o_variate         = r_od_res;
    assign o_took_reciprocal = r_od_took;
    assign o_saturated       = r_od_sat;

endmodule

// ===== src/igs_checker.sv =====
// ----------------------------------------------------------------------------
// igs_checker
// Port-level checks for the inverse Gaussian sampler, bound to the top level.
// ----------------------------------------------------------------------------
module igs_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [igs_pkg::DATA_W-1:0]   o_variate,
    input logic                         o_took_reciprocal,
    input logic                         o_saturated
);

    localparam int DW = igs_pkg::DATA_W;
    localparam int VW = (VALUE_WIDTH > DW) ? DW : VALUE_WIDTH;
    localparam logic [DW-1:0] VMAX = {DW{1'b1}} >> (DW - VW);

    // Input backpressure only starts while a result sits stalled at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall rose without a stalled output word");

    // A clipped word always carries the maximum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_variate == VMAX))
        else $error("saturated word below maximum");

    // Stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_variate)
                                  && $stable(o_took_reciprocal) && $stable(o_saturated)))
        else $error("stalled output word changed");

    // Reset empties the output and releases the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output or stall active after reset");

endmodule

bind inverse_gaussian_sampler_unit igs_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_igs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_variate         (o_variate),
    .o_took_reciprocal (o_took_reciprocal),
    .o_saturated       (o_saturated)
);

// ===== tb/inverse_gaussian_sampler_checker.sv =====
// ----------------------------------------------------------------------------
// inverse_gaussian_sampler_checker
// Watches the config port and both word channels of the sampler, predicts
// each variate from its own copy of lambda and mu, and compares in order.
// ----------------------------------------------------------------------------
module inverse_gaussian_sampler_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [igs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [igs_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_stall_in,
    input  logic [igs_pkg::DATA_W-1:0]    i_normal_sample,
    input  logic [igs_pkg::DATA_W-1:0]    i_uniform_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [igs_pkg::DATA_W-1:0]    i_variate,
    input  logic                          i_took_reciprocal,
    input  logic                          i_saturated,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_recip_count,
    output int                            o_sat_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] variate;
        logic        took;
        logic        sat;
    } variate_t;

    logic [31:0] shape_lambda_q;
    logic [31:0] mean_mu_q;
    variate_t    variate_queue[$];

    // Michael-Schucany-Haas transform at full width
    function automatic variate_t predict_variate(logic [31:0] nraw, logic [31:0] zraw,
                                                 logic [31:0] lam, logic [31:0] mu);
        logic [32:0]  mag;
        logic [63:0]  y, a, s, c, x1, res;
        logic [127:0] p, rad, num, lhs, rhs;
        variate_t     r;
        mag = nraw[31] ? (33'h1_0000_0000 - {1'b0, nraw}) : {1'b0, nraw};
        y   = 64'(mag) * 64'(mag);
        p   = 128'(mu) * 128'(y);
        a   = 64'(p >> 40);
        if (a == 0) begin
            x1 = 64'(mu);
        end else begin
            rad = 128'(a) * 128'(a) + ((128'(lam) * 128'(a)) << 18);
            s = 0;
            for (int b = 63; b >= 0; b--) begin
                c = s | (64'd1 << b);
                if (128'(c) * 128'(c) <= rad) s = c;
            end
            num = 128'(mu) * 128'(s - a);
            x1  = 64'(num / 128'(s + a));
        end
        lhs = 128'(zraw) * (128'(mu) + 128'(x1));
        rhs = 128'(mu) << 32;
        r.took = 1'b0;
        r.sat  = 1'b0;
        if (lhs <= rhs) begin
            res = x1;
        end else begin
            r.took = 1'b1;
            if (x1 == 0) begin
                res   = 64'hFFFF_FFFF;
                r.sat = 1'b1;
            end else begin
                res = (64'(mu) * 64'(mu)) / x1;
            end
        end
        if (res > 64'hFFFF_FFFF) begin
            res   = 64'hFFFF_FFFF;
            r.sat = 1'b1;
        end
        r.variate = res[31:0];
        return r;
    endfunction

    assign o_pending = variate_queue.size();

    always @(posedge i_clk) begin
        variate_t expd;
        if (!i_rst_n) begin
            shape_lambda_q <= igs_pkg::CFG_RESET;
            mean_mu_q      <= igs_pkg::CFG_RESET;
            variate_queue.delete();
            o_fail_count   <= 0;
            o_recip_count  <= 0;
            o_sat_count    <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    igs_pkg::REG_SHAPE_LAMBDA: shape_lambda_q <= i_cfg_data;
                    igs_pkg::REG_MEAN_MU:      mean_mu_q      <= i_cfg_data;
                    default: ;
                endcase
            end
            // accepted input word
            if (i_valid && !i_stall_in)
                variate_queue.push_back(predict_variate(i_normal_sample, i_uniform_sample,
                                                        shape_lambda_q, mean_mu_q));
            // accepted result word
            if (i_out_valid && !i_out_stall) begin
                if (variate_queue.size() == 0) begin
                    $display("%0t: unexpected result variate=%h took=%b sat=%b",
                             $time, i_variate, i_took_reciprocal, i_saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    expd = variate_queue.pop_front();
                    if (expd.variate !== i_variate || expd.took !== i_took_reciprocal ||
                        expd.sat !== i_saturated) begin
                        $display("%0t: mismatch expected variate=%h took=%b sat=%b, got %h %b %b",
                                 $time, expd.variate, expd.took, expd.sat,
                                 i_variate, i_took_reciprocal, i_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (expd.took) o_recip_count <= o_recip_count + 1;
                    if (expd.sat)  o_sat_count   <= o_sat_count + 1;
                end
            end
        end
    end

endmodule

// ===== tb/inverse_gaussian_sampler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// inverse_gaussian_sampler_unit_tb
// Drives directed and random normal/uniform word pairs through the sampler
// under several lambda/mu settings and idle patterns; the checker judges.
// ----------------------------------------------------------------------------
module inverse_gaussian_sampler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [igs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [igs_pkg::DATA_W-1:0]    i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [igs_pkg::DATA_W-1:0]    i_normal_sample = '0;
    logic [igs_pkg::DATA_W-1:0]    i_uniform_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [igs_pkg::DATA_W-1:0]    o_variate;
    logic                          o_took_reciprocal;
    logic                          o_saturated;

    int fail_count, pending, recip_count, sat_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int word_count = 0;

    inverse_gaussian_sampler_unit #(.VALUE_WIDTH(32)) DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_stall,
        .i_normal_sample(signed'(i_normal_sample)), .i_uniform_sample,
        .o_valid, .i_stall, .o_variate, .o_took_reciprocal, .o_saturated
    );

    inverse_gaussian_sampler_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_stall_in(o_stall), .i_normal_sample, .i_uniform_sample,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_variate(o_variate),
        .i_took_reciprocal(o_took_reciprocal), .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_recip_count(recip_count), .o_sat_count(sat_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk)
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    task automatic write_reg(logic [igs_pkg::CFG_IDX_W-1:0] idx,
                             logic [igs_pkg::DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // wait for every expected word, then set lambda and mu
    task automatic set_params(logic [31:0] lam, logic [31:0] mu);
        while (pending != 0) @(negedge i_clk);
        write_reg(igs_pkg::REG_SHAPE_LAMBDA, lam);
        write_reg(igs_pkg::REG_MEAN_MU, mu);
    endtask

    // one word on the input channel, held until accepted
    task automatic send_word(logic [31:0] nu, logic [31:0] z);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_normal_sample  = nu;
        i_uniform_sample = z;
        do @(posedge i_clk); while (o_stall);
        word_count++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_normal();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom();
            1:       v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       v = 32'h8000_0000 + $urandom_range(0, 3);
            3:       v = $urandom_range(0, 7) - 3;
            default: begin
                v = $urandom() >> $urandom_range(1, 28);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_param();
        case ($urandom_range(0, 3))
            0:       return $urandom() | 32'd1;
            1:       return $urandom_range(1, 32'h000F_FFFF);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    task automatic run_random(logic [31:0] lam, logic [31:0] mu, int n);
        set_params(lam, mu);
        for (int k = 0; k < n; k++) send_word(rand_normal(), $urandom());
    endtask

    initial begin
        logic [31:0] nu_edge[6];
        nu_edge = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0001};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: normal extremes against both uniform extremes, reset params
        foreach (nu_edge[k]) begin
            send_word(nu_edge[k], 32'h0);
            send_word(nu_edge[k], 32'hFFFF_FFFF);
        end
        // parameter extremes: tiny lambda forces tiny x1, big reciprocal clips
        set_params(32'd1, 32'hFFFF_FFFF);
        send_word(32'h1000_0000, 32'hFFFF_FFFF);
        send_word(32'h0, 32'hFFFF_FFFF);
        send_word(32'h8000_0000, 32'h8000_0000);
        set_params(32'hFFFF_FFFF, 32'd1);
        send_word(32'h1000_0000, 32'hFFFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h0);
        send_word(32'h0, 32'hFFFF_FFFF);
        set_params(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hF000_0000, 32'hFFFF_FFFF);
        send_word(32'h0000_0001, 32'h8000_0000);
        set_params(32'd1, 32'd1);
        send_word(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h8000_0000, 32'h0);

        // sender mostly active, receiver mostly stalled
        send_idle_pct = 24; recv_idle_pct = 88;
        run_random(igs_pkg::CFG_RESET, igs_pkg::CFG_RESET, 280);
        run_random(32'd1, 32'hFFFF_FFFF, 280);
        // roles swapped
        send_idle_pct = 88; recv_idle_pct = 24;
        run_random(32'hFFFF_FFFF, 32'd1, 280);
        run_random(rand_param(), rand_param(), 280);
        // full rate
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(32'hFFFF_FFFF, 32'hFFFF_FFFF, 280);
        for (int k = 0; k < 4; k++) run_random(rand_param(), rand_param(), 70);

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d words over 14 lambda/mu settings and three idle patterns.",
                 word_count);
        $display("Reciprocal path taken %0d times, saturation seen %0d times.",
                 recip_count, sat_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/igs_pkg.sv
src/inverse_gaussian_sampler_unit.sv
src/igs_checker.sv
tb/inverse_gaussian_sampler_checker.sv
tb/inverse_gaussian_sampler_unit_tb.sv
